>>> sv/stim_pkg.sv
// types and constants shared by the striped tile index map
// depends on nothing
package stim_pkg;

  localparam int IdxW  = 24;
  localparam int CrdW  = 12;
  localparam int SideW = 13;
  localparam int SpanW = 2 * SideW;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STRIPE  = 2'd2;

  localparam logic KIND_TO_INDEX  = 1'b0;
  localparam logic KIND_TO_COORDS = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [CrdW-1:0] tile_col;
    logic [CrdW-1:0] tile_row;
    logic [IdxW-1:0] seq_index;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] out_index;
    logic [CrdW-1:0] out_col;
    logic [CrdW-1:0] out_row;
    logic            out_of_range;
  } rsp_t;

  // carried through the first divider
  typedef struct packed {
    logic            kind;
    logic            bad;
    logic [CrdW-1:0] col;
  } p1_t;

  // carried through the second divider
  typedef struct packed {
    logic            kind;
    logic            bad;
    logic [CrdW-1:0] base;
    logic [IdxW-1:0] sum;
    logic [IdxW-1:0] prod;
  } p2_t;

endpackage

>>> sv/stim_cell.sv
// one restoring division step with a side payload, registered
// depends on nothing
module stim_cell #(
  parameter int NW = 24,
  parameter int DW = 26,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [NW-1:0] in_nq,
  input  logic [DW-1:0] in_div,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [NW-1:0] out_nq,
  output logic [DW-1:0] out_div,
  output logic [PW-1:0] out_pay
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;

  always_comb begin
    trial = {in_rem, in_nq[NW-1]};
    ge    = trial >= {1'b0, in_div};
    diff  = trial - {1'b0, in_div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
    out_nq  <= {in_nq[NW-2:0], ge};
    out_div <= in_div;
    out_pay <= in_pay;
  end

endmodule

>>> sv/stim_div.sv
// pipelined divider: a chain of division cells, one quotient bit per cell
// depends on stim_cell
module stim_div #(
  parameter int NW = 24,
  parameter int DW = 26,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] div,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [PW-1:0] out_pay
);

  logic          v   [NW+1];
  logic [DW-1:0] r   [NW+1];
  logic [NW-1:0] nq  [NW+1];
  logic [DW-1:0] d   [NW+1];
  logic [PW-1:0] p   [NW+1];

  assign v[0]  = in_valid;
  assign r[0]  = '0;
  assign nq[0] = num;
  assign d[0]  = div;
  assign p[0]  = in_pay;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    stim_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[k]),
      .in_rem   (r[k]),
      .in_nq    (nq[k]),
      .in_div   (d[k]),
      .in_pay   (p[k]),
      .out_valid(v[k+1]),
      .out_rem  (r[k+1]),
      .out_nq   (nq[k+1]),
      .out_div  (d[k+1]),
      .out_pay  (p[k+1])
    );
  end

  assign out_valid = v[NW];
  assign quo       = nq[NW];
  assign rem       = r[NW];
  assign out_pay   = p[NW];

endmodule

>>> sv/striped_tile_index_map.sv
// top level of the striped tile index map: config registers, pipeline stages
// depends on stim_pkg and stim_div
//
//  channel   handshake               payload
//  request   start / busy            req   (stim_pkg::req_t)
//  result    done (strobe)           rsp   (stim_pkg::rsp_t)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one request per cycle; each result passes through two 24-cell divider chains
// plus five single stages
// busy is high and cfg_ready low only during reset; synchronous active-high reset
// results cannot be stalled, done is high for exactly one cycle per result
module striped_tile_index_map #(
  parameter int MAX_GRID_SIDE = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  stim_pkg::req_t                      req,
  output logic                                done,
  output stim_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stim_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [stim_pkg::SideW-1:0]          cfg_data
);

  localparam int IdxW  = stim_pkg::IdxW;
  localparam int CrdW  = stim_pkg::CrdW;
  localparam int SideW = stim_pkg::SideW;
  localparam int SpanW = stim_pkg::SpanW;
  localparam int P1W   = $bits(stim_pkg::p1_t);
  localparam int P2W   = $bits(stim_pkg::p2_t);
  localparam int Latency = 2 * IdxW + 5;

  logic [SideW-1:0] grid_columns;
  logic [SideW-1:0] grid_rows;
  logic [SideW-1:0] stripe_height;
  logic [SideW-1:0] clamped;
  logic [SideW-1:0] sf0;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign clamped   = (32'(cfg_data) > 32'(MAX_GRID_SIDE)) ?
                     SideW'(MAX_GRID_SIDE) : cfg_data;
  assign sf0       = (stripe_height == '0) ? SideW'(1) : stripe_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns  <= SideW'(1);
      grid_rows     <= SideW'(1);
      stripe_height <= SideW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stim_pkg::CFG_COLUMNS: grid_columns  <= clamped;
        stim_pkg::CFG_ROWS:    grid_rows     <= clamped;
        stim_pkg::CFG_STRIPE:  stripe_height <= clamped;
        default: ;
      endcase
    end
  end

  // stage 0: range check, divisor select
  logic [SpanW-1:0] span;
  logic [SpanW-1:0] area;
  logic             in_bad;
  logic             s0_valid;
  logic [IdxW-1:0]  s0_num;
  logic [SpanW-1:0] s0_div;
  stim_pkg::p1_t    s0_pay;

  assign span = SpanW'(sf0) * SpanW'(grid_columns);
  assign area = SpanW'(grid_columns) * SpanW'(grid_rows);

  always_comb begin
    if (req.kind == stim_pkg::KIND_TO_INDEX) begin
      in_bad = ({1'b0, req.tile_col} >= grid_columns) ||
               ({1'b0, req.tile_row} >= grid_rows);
    end else begin
      in_bad = SpanW'(req.seq_index) >= area;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_num     <= (req.kind == stim_pkg::KIND_TO_INDEX) ?
                  IdxW'(req.tile_row) : req.seq_index;
    s0_div     <= (req.kind == stim_pkg::KIND_TO_INDEX) ? SpanW'(sf0) : span;
    s0_pay.kind <= req.kind;
    s0_pay.bad  <= in_bad;
    s0_pay.col  <= req.tile_col;
  end

  // stripe number and offset within the stripe
  logic             d1_valid;
  logic [IdxW-1:0]  d1_quo;
  logic [SpanW-1:0] d1_rem;
  logic [P1W-1:0]   d1_pay_bits;
  stim_pkg::p1_t    d1_pay;

  stim_div #(.NW(IdxW), .DW(SpanW), .PW(P1W)) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_valid),
    .num      (s0_num),
    .div      (s0_div),
    .in_pay   (s0_pay),
    .out_valid(d1_valid),
    .quo      (d1_quo),
    .rem      (d1_rem),
    .out_pay  (d1_pay_bits)
  );
  assign d1_pay = stim_pkg::p1_t'(d1_pay_bits);

  // stage 2: stripe base row and index of the stripe start
  logic                  s2_valid;
  stim_pkg::p1_t         s2_pay;
  logic [CrdW-1:0]       s2_base;
  logic [IdxW-1:0]       s2_qspan;
  logic [IdxW-1:0]       s2_rem;
  logic [CrdW+SideW-1:0] base_full;
  logic [CrdW+SpanW-1:0] qspan_full;

  assign base_full  = (CrdW+SideW)'(d1_quo[CrdW-1:0]) * (CrdW+SideW)'(sf0);
  assign qspan_full = (CrdW+SpanW)'(d1_quo[CrdW-1:0]) * (CrdW+SpanW)'(span);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= d1_valid;
    end
    s2_pay   <= d1_pay;
    s2_base  <= base_full[CrdW-1:0];
    s2_qspan <= qspan_full[IdxW-1:0];
    s2_rem   <= d1_rem[IdxW-1:0];
  end

  // stage 3: height of the current stripe
  logic             s3_valid;
  stim_pkg::p1_t    s3_pay;
  logic [CrdW-1:0]  s3_base;
  logic [IdxW-1:0]  s3_sum;
  logic [IdxW-1:0]  s3_rem;
  logic [SideW-1:0] s3_cur;
  logic [SideW:0]   base_end;

  assign base_end = (SideW+1)'(s2_base) + (SideW+1)'(sf0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_pay  <= s2_pay;
    s3_base <= s2_base;
    s3_sum  <= s2_qspan + s2_rem;
    s3_rem  <= s2_rem;
    s3_cur  <= (base_end < (SideW+1)'(grid_rows)) ?
               sf0 : grid_rows - SideW'(s2_base);
  end

  // stage 4: column times stripe height
  logic                  s4_valid;
  logic [IdxW-1:0]       s4_rem;
  logic [SideW-1:0]      s4_cur;
  stim_pkg::p2_t         s4_pay;
  logic [CrdW+SideW-1:0] prod_full;

  assign prod_full = (CrdW+SideW)'(s3_pay.col) * (CrdW+SideW)'(s3_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_rem      <= s3_rem;
    s4_cur      <= s3_cur;
    s4_pay.kind <= s3_pay.kind;
    s4_pay.bad  <= s3_pay.bad;
    s4_pay.base <= s3_base;
    s4_pay.sum  <= s3_sum;
    s4_pay.prod <= prod_full[IdxW-1:0];
  end

  // column and row within the stripe
  logic             d2_valid;
  logic [IdxW-1:0]  d2_quo;
  logic [SideW-1:0] d2_rem;
  logic [P2W-1:0]   d2_pay_bits;
  stim_pkg::p2_t    d2_pay;

  stim_div #(.NW(IdxW), .DW(SideW), .PW(P2W)) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s4_valid),
    .num      (s4_rem),
    .div      (s4_cur),
    .in_pay   (s4_pay),
    .out_valid(d2_valid),
    .quo      (d2_quo),
    .rem      (d2_rem),
    .out_pay  (d2_pay_bits)
  );
  assign d2_pay = stim_pkg::p2_t'(d2_pay_bits);

  // result register
  stim_pkg::rsp_t rsp_next;

  always_comb begin
    rsp_next = '0;
    if (d2_pay.bad) begin
      rsp_next.out_of_range = 1'b1;
    end else if (d2_pay.kind == stim_pkg::KIND_TO_INDEX) begin
      rsp_next.out_index = d2_pay.sum + d2_pay.prod;
    end else begin
      rsp_next.out_col = d2_quo[CrdW-1:0];
      rsp_next.out_row = d2_rem[CrdW-1:0] + d2_pay.base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_valid;
    end
    rsp <= rsp_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Latency done)
    else $error("request without result");

  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result without request");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.out_of_range) |->
      (rsp.out_index == '0 && rsp.out_col == '0 && rsp.out_row == '0))
    else $error("out of range result carries data");

  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.out_index == '0 || (rsp.out_col == '0 && rsp.out_row == '0)))
    else $error("index and coordinates both set");

endmodule

>>> test/striped_tile_index_map_test.sv
// testbench for the striped tile index map: directed and random translations
// checked against a built-in predictor; depends on stim_pkg and the block's rtl
`timescale 1ns / 100ps
module striped_tile_index_map_test;

  localparam int CfgIdxW = stim_pkg::CfgIdxW;
  localparam int SideW   = stim_pkg::SideW;
  localparam int IdxW    = stim_pkg::IdxW;
  localparam int CrdW    = stim_pkg::CrdW;
  localparam int MaxSide = 4096;

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  stim_pkg::req_t req;
  stim_pkg::rsp_t rsp;
  logic [CfgIdxW-1:0] cfg_index;
  logic [SideW-1:0] cfg_data;

  stim_pkg::req_t pending_reqs[$];
  stim_pkg::rsp_t expected_maps[$];
  longint unsigned grid_cols, grid_rows, stripe_rows;
  int idle_pct, errors, cycles, accepted, checked;

  striped_tile_index_map u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned clamp_side(logic [SideW-1:0] v);
    return (v > MaxSide) ? MaxSide : v;
  endfunction

  function automatic stim_pkg::rsp_t map_tile(stim_pkg::req_t r);
    stim_pkg::rsp_t m;
    longint unsigned sh, top_st, top_base, cur, base, idx, span, z, st, off, ci, rj;
    m = '0;
    m.out_of_range = 1'b1;
    sh = (stripe_rows == 0) ? 1 : stripe_rows;
    if (grid_cols == 0 || grid_rows == 0) return m;
    top_st = (grid_rows - 1) / sh;
    top_base = top_st * sh;
    if (r.kind == stim_pkg::KIND_TO_INDEX) begin
      if (r.tile_col >= grid_cols || r.tile_row >= grid_rows) return m;
      cur = (r.tile_row < top_base) ? sh : grid_rows - top_base;
      base = (r.tile_row / sh) * sh;
      idx = base * grid_cols + (r.tile_row - base) + r.tile_col * cur;
      if (idx > 64'hFFFFFF) return m;
      m.out_index = idx[IdxW-1:0];
    end else begin
      z = r.seq_index;
      span = sh * grid_cols;
      if (z >= grid_cols * grid_rows) return m;
      cur = (z < top_st * span) ? sh : grid_rows - top_base;
      st = z / span;
      off = z - st * span;
      ci = off / cur;
      rj = off - ci * cur + st * sh;
      if (ci > 12'hFFF || rj > 12'hFFF) return m;
      m.out_col = ci[CrdW-1:0];
      m.out_row = rj[CrdW-1:0];
    end
    m.out_of_range = 1'b0;
    return m;
  endfunction

  function automatic stim_pkg::req_t rand_req();
    stim_pkg::req_t r;
    r.kind = 1'($urandom_range(1));
    r.tile_col = CrdW'($urandom);
    r.tile_row = CrdW'($urandom);
    r.seq_index = IdxW'($urandom);
    if ($urandom_range(9) < 8 && grid_cols != 0 && grid_rows != 0) begin
      r.tile_col = CrdW'($urandom_range(32'(grid_cols - 1)));
      r.tile_row = CrdW'($urandom_range(32'(grid_rows - 1)));
      r.seq_index = IdxW'($urandom_range(32'(grid_cols * grid_rows - 1)));
    end
    return r;
  endfunction

  function automatic stim_pkg::req_t make_req(logic k, int c, int rw, int s);
    stim_pkg::req_t r;
    r.kind = k;
    r.tile_col = CrdW'(c);
    r.tile_row = CrdW'(rw);
    r.seq_index = IdxW'(s);
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      req <= pending_reqs[0];
    end else begin
      start <= 1'b0;
    end
  end

  // request acceptance, result monitor and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("striped_tile_index_map_test: done, errors");
      $finish;
    end else if (!rst) begin
      if (start && !busy) begin
        expected_maps.push_back(map_tile(req));
        void'(pending_reqs.pop_front());
        accepted <= accepted + 1;
      end
      if (done) begin
        if (expected_maps.size() == 0) begin
          $error("unexpected result");
          errors = errors + 1;
        end else begin
          checked <= checked + 1;
          if (rsp.out_index !== expected_maps[0].out_index) begin
            $error("out_index exp %0h got %0h", expected_maps[0].out_index, rsp.out_index);
            errors = errors + 1;
          end
          if (rsp.out_col !== expected_maps[0].out_col) begin
            $error("out_col exp %0h got %0h", expected_maps[0].out_col, rsp.out_col);
            errors = errors + 1;
          end
          if (rsp.out_row !== expected_maps[0].out_row) begin
            $error("out_row exp %0h got %0h", expected_maps[0].out_row, rsp.out_row);
            errors = errors + 1;
          end
          if (rsp.out_of_range !== expected_maps[0].out_of_range) begin
            $error("out_of_range exp %0b got %0b", expected_maps[0].out_of_range,
                   rsp.out_of_range);
            errors = errors + 1;
          end
          void'(expected_maps.pop_front());
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SideW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == stim_pkg::CFG_COLUMNS) grid_cols = clamp_side(val);
    else if (idx == stim_pkg::CFG_ROWS) grid_rows = clamp_side(val);
    else if (idx == stim_pkg::CFG_STRIPE) stripe_rows = clamp_side(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_maps.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  int shapes[12][3] = '{
    '{4096, 4096, 4096}, '{8191, 8191, 0}, '{7, 10, 3}, '{0, 5, 2}, '{5, 0, 2},
    '{13, 9, 20}, '{100, 37, 8}, '{3, 4096, 1}, '{4096, 1, 5}, '{1, 1, 1},
    '{4096, 4096, 7}, '{6000, 2, 4097}
  };

  initial begin
    clk = 0; rst = 1; start = 0; req = '0; cfg_valid = 0;
    cfg_index = stim_pkg::CFG_COLUMNS;
    cfg_data = '0; idle_pct = 0; errors = 0; cycles = 0; accepted = 0; checked = 0;
    grid_cols = 1; grid_rows = 1; stripe_rows = 1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // reset shape, then directed corners on the full grid
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 0, 0, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 1));
    drain();
    write_reg(stim_pkg::CFG_COLUMNS, SideW'(4096));
    write_reg(stim_pkg::CFG_ROWS, SideW'(4096));
    write_reg(stim_pkg::CFG_STRIPE, SideW'(3));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 0, 0, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 4095, 4095, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 4095, 0, 24'hFFFFFF));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 0, 4095, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 123, 4094, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 4095, 4095, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 24'hFFFFFF));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 24'hFFFFFE));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 24'hFFF000));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 4095 * 3 * 4096));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 12287));
    drain();
    write_reg(stim_pkg::CFG_COLUMNS, SideW'(5));
    write_reg(stim_pkg::CFG_ROWS, SideW'(7));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 5, 0, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 0, 7, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_INDEX, 4, 6, 0));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 34));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 35));
    pending_reqs.push_back(make_req(stim_pkg::KIND_TO_COORDS, 0, 0, 31));
    drain();
    for (int p = 0; p < 12; p++) begin
      write_reg(stim_pkg::CFG_COLUMNS, SideW'(shapes[p][0]));
      write_reg(stim_pkg::CFG_ROWS, SideW'(shapes[p][1]));
      write_reg(stim_pkg::CFG_STRIPE, SideW'(shapes[p][2]));
      unique case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 86;
        2: idle_pct = 0;
        default: idle_pct = 16;
      endcase
      for (int n = 0; n < 52; n++) pending_reqs.push_back(rand_req());
      drain();
    end
    $display("covered %0d requests, %0d results checked over 15 grid shapes", accepted,
             checked);
    $display("shapes incl. empty grid, zero stripe, clamped sides, stripe over grid");
    if (errors == 0 && expected_maps.size() == 0) begin
      $display("striped_tile_index_map_test: done, clean");
    end else begin
      $display("striped_tile_index_map_test: done, errors");
    end
    $finish;
  end
endmodule
